// ===== src/vad_pkg.sv =====
// Package with beat types, stage payloads and the cosine threshold table.
`default_nettype none
package vad_pkg;

    localparam int COORD_BITS = 32;
    localparam int MAG_BITS   = 64;
    localparam int WIDE_BITS  = 128;
    localparam int QUO_BITS   = 65;
    localparam int DIV_STEPS  = 64;
    localparam int NUM_HALF   = 90;
    localparam int IDX_BITS   = 7;
    localparam int SRCH_STEPS = 7;
    localparam int ANGLE_BITS = 8;

    localparam logic [ANGLE_BITS-1:0] ANGLE_RIGHT = ANGLE_BITS'(90);
    localparam logic [ANGLE_BITS-1:0] ANGLE_MAX   = ANGLE_BITS'(180);

    localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
    localparam logic [63:0] ONE_Q60  = 64'h1000000000000000;
    localparam logic [63:0] STEP_Q60 = PI_Q60 / 360;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] az;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic signed [COORD_BITS-1:0] bz;
    } vad_in_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] angle_deg;
        logic                  zero_length;
    } vad_out_t;

    // Classification of one beat that rides along from stage 4 to the output.
    typedef struct packed {
        logic zero_len;
        logic dzero;
        logic dneg;
    } vad_tag_t;

    typedef struct packed {
        logic [WIDE_BITS-1:0] den;
        logic [WIDE_BITS-1:0] rem;
        logic [QUO_BITS-1:0]  quo;
        vad_tag_t             tag;
    } vad_div_t;

    typedef struct packed {
        logic [QUO_BITS-1:0] quo;
        logic                eq_ok;
        logic [IDX_BITS-1:0] lo;
        logic [IDX_BITS-1:0] hi;
        vad_tag_t            tag;
    } vad_srch_t;

    typedef logic [NUM_HALF-1:0][63:0] cos_tab_t;

    // Unsigned 64-bit shift-and-subtract quotient, used only while building the table.
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        int          b;
        quo = '0;
        rem = '0;
        for (b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Squared cosine of (j + 0.5) degrees in Q0.64, from a Taylor series in Q4.60.
    function automatic cos_tab_t build_cos_tab();
        cos_tab_t       tab;
        logic [63:0]    x;
        logic [63:0]    x2;
        logic [63:0]    term;
        logic [63:0]    sum;
        logic [63:0]    tm;
        logic [63:0]    den;
        logic [127:0]   prod;
        int             j;
        int             n;
        for (j = 0; j < NUM_HALF; j++)
        begin
            x    = STEP_Q60 * 64'(2 * j + 1);
            prod = {64'd0, x} * {64'd0, x};
            x2   = prod[123:60];
            term = ONE_Q60;
            sum  = ONE_Q60;
            for (n = 1; n <= 30; n++)
            begin
                prod = {64'd0, term} * {64'd0, x2};
                den  = 64'((2 * n - 1) * (2 * n));
                term = udiv64(prod[123:60], den);
                if ((n & 1) == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            if (sum[63])
                sum = 64'd0;
            tm     = (sum + 64'h8000000) >> 28;
            tab[j] = tm * tm;
        end
        return tab;
    endfunction

    localparam cos_tab_t COS_SQ = build_cos_tab();

endpackage
`default_nettype wire

// ===== src/vector_angle_degrees_3d.sv =====
// Angle between two 3D vectors in whole degrees, fully pipelined.
// Throughput is one beat per cycle while the output is not stalled; the 64-stage restoring divider sets the depth.
// A stalled output freezes every stage, so nothing is lost or repeated.
// Reset clears all valid bits at once; the block keeps no other state.
`default_nettype none
module vector_angle_degrees_3d
    import vad_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    input  wire vad_in_t in_data,
    output logic         out_valid,
    input  wire logic    out_stall,
    output vad_out_t     out_data
);

    logic ce;

    // Stage 1: magnitudes and sign relations.
    logic                        s1_valid_reg;
    logic [2:0][COORD_BITS-1:0]  ma_reg, ma_next;
    logic [2:0][COORD_BITS-1:0]  mb_reg, mb_next;
    logic [2:0]                  ng_reg, ng_next;
    logic                        s1_zero_reg, s1_zero_next;
    logic [2:0][COORD_BITS-1:0]  ca;
    logic [2:0][COORD_BITS-1:0]  cb;

    // Stage 2: component products.
    logic                        s2_valid_reg;
    logic [2:0][MAG_BITS-1:0]    sqa_reg, sqb_reg, cr_reg;
    logic [2:0]                  s2_ng_reg;
    logic                        s2_zero_reg;

    // Stage 3: sums.
    logic                        s3_valid_reg;
    logic [MAG_BITS-1:0]         a2_reg, a2_next, b2_reg, b2_next;
    logic [MAG_BITS-1:0]         pos_reg, pos_next, neg_reg, neg_next;
    logic                        s3_zero_reg;

    // Stage 4: dot magnitude and sign.
    logic                        s4_valid_reg;
    logic [MAG_BITS-1:0]         dmag_reg, dmag_next;
    logic [MAG_BITS-1:0]         s4_a2_reg, s4_b2_reg;
    vad_tag_t                    s4_tag_reg, s4_tag_next;

    // Stage 5: 32x32 partial products.
    logic                        s5_valid_reg;
    logic [MAG_BITS-1:0]         d00_reg, d01_reg, d11_reg;
    logic [MAG_BITS-1:0]         p00_reg, p01_reg, p10_reg, p11_reg;
    vad_tag_t                    s5_tag_reg;

    // Stage 6: squared dot and norm product.
    logic                        s6_valid_reg;
    logic [WIDE_BITS-1:0]        dsq_reg, dsq_next, pn_reg, pn_next;
    vad_tag_t                    s6_tag_reg;

    // Stage 7: top quotient bit.
    logic                        s7_valid_reg;
    vad_div_t                    s7_reg, s7_next;

    logic [DIV_STEPS:0]          dv_valid;
    vad_div_t [DIV_STEPS:0]      dv_data;
    logic [SRCH_STEPS:0]         sr_valid;
    vad_srch_t [SRCH_STEPS:0]    sr_data;

    logic                        out_valid_reg;
    vad_out_t                    out_reg, out_next;

    assign ce       = !(out_valid_reg && out_stall);
    assign in_stall = !ce;

    always_comb
    begin
        ca = {in_data.az, in_data.ay, in_data.ax};
        cb = {in_data.bz, in_data.by, in_data.bx};
        for (int i = 0; i < 3; i++)
        begin
            ma_next[i] = ca[i][COORD_BITS-1] ? (~ca[i] + 1'b1) : ca[i];
            mb_next[i] = cb[i][COORD_BITS-1] ? (~cb[i] + 1'b1) : cb[i];
            ng_next[i] = ca[i][COORD_BITS-1] ^ cb[i][COORD_BITS-1];
        end
        s1_zero_next = (ca == '0) || (cb == '0);
    end

    always_comb
    begin
        a2_next  = sqa_reg[0] + sqa_reg[1] + sqa_reg[2];
        b2_next  = sqb_reg[0] + sqb_reg[1] + sqb_reg[2];
        pos_next = '0;
        neg_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (s2_ng_reg[i])
                neg_next = neg_next + cr_reg[i];
            else
                pos_next = pos_next + cr_reg[i];
        end
    end

    always_comb
    begin
        s4_tag_next.zero_len = s3_zero_reg;
        s4_tag_next.dneg     = neg_reg > pos_reg;
        s4_tag_next.dzero    = neg_reg == pos_reg;
        dmag_next = s4_tag_next.dneg ? (neg_reg - pos_reg) : (pos_reg - neg_reg);
    end

    always_comb
    begin
        dsq_next = ({d11_reg, 64'd0})
                 + ({31'd0, d01_reg, 33'd0})
                 + ({64'd0, d00_reg});
        pn_next  = ({p11_reg, 64'd0})
                 + ({32'd0, p01_reg, 32'd0})
                 + ({32'd0, p10_reg, 32'd0})
                 + ({64'd0, p00_reg});
    end

    always_comb
    begin
        s7_next.den = pn_reg;
        s7_next.tag = s6_tag_reg;
        if (dsq_reg >= pn_reg)
        begin
            s7_next.rem = dsq_reg - pn_reg;
            s7_next.quo = QUO_BITS'(1);
        end
        else
        begin
            s7_next.rem = dsq_reg;
            s7_next.quo = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ma_reg      <= ma_next;
            mb_reg      <= mb_next;
            ng_reg      <= ng_next;
            s1_zero_reg <= s1_zero_next;

            for (int i = 0; i < 3; i++)
            begin
                sqa_reg[i] <= {32'd0, ma_reg[i]} * {32'd0, ma_reg[i]};
                sqb_reg[i] <= {32'd0, mb_reg[i]} * {32'd0, mb_reg[i]};
                cr_reg[i]  <= {32'd0, ma_reg[i]} * {32'd0, mb_reg[i]};
            end
            s2_ng_reg   <= ng_reg;
            s2_zero_reg <= s1_zero_reg;

            a2_reg      <= a2_next;
            b2_reg      <= b2_next;
            pos_reg     <= pos_next;
            neg_reg     <= neg_next;
            s3_zero_reg <= s2_zero_reg;

            dmag_reg    <= dmag_next;
            s4_a2_reg   <= a2_reg;
            s4_b2_reg   <= b2_reg;
            s4_tag_reg  <= s4_tag_next;

            d00_reg <= {32'd0, dmag_reg[31:0]}  * {32'd0, dmag_reg[31:0]};
            d01_reg <= {32'd0, dmag_reg[31:0]}  * {32'd0, dmag_reg[63:32]};
            d11_reg <= {32'd0, dmag_reg[63:32]} * {32'd0, dmag_reg[63:32]};
            p00_reg <= {32'd0, s4_a2_reg[31:0]}  * {32'd0, s4_b2_reg[31:0]};
            p01_reg <= {32'd0, s4_a2_reg[31:0]}  * {32'd0, s4_b2_reg[63:32]};
            p10_reg <= {32'd0, s4_a2_reg[63:32]} * {32'd0, s4_b2_reg[31:0]};
            p11_reg <= {32'd0, s4_a2_reg[63:32]} * {32'd0, s4_b2_reg[63:32]};
            s5_tag_reg <= s4_tag_reg;

            dsq_reg    <= dsq_next;
            pn_reg     <= pn_next;
            s6_tag_reg <= s5_tag_reg;

            s7_reg <= s7_next;
        end
    end

    assign dv_valid[0] = s7_valid_reg;
    assign dv_data[0]  = s7_reg;

    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_div
        vad_div_step u_step (
            .clk        (clk),
            .rst_n      (rst_n),
            .ce         (ce),
            .prev_valid (dv_valid[g]),
            .prev_data  (dv_data[g]),
            .valid      (dv_valid[g+1]),
            .data       (dv_data[g+1])
        );
    end

    // Equality with a threshold counts as "below" only when the division was exact
    // and the dot product is not negative.
    assign sr_data[0] = {dv_data[DIV_STEPS].quo,
                         !dv_data[DIV_STEPS].tag.dneg && (dv_data[DIV_STEPS].rem == '0),
                         IDX_BITS'(0),
                         IDX_BITS'(NUM_HALF),
                         dv_data[DIV_STEPS].tag};
    assign sr_valid[0] = dv_valid[DIV_STEPS];

    for (genvar g = 0; g < SRCH_STEPS; g++)
    begin : g_srch
        vad_search_step u_step (
            .clk        (clk),
            .rst_n      (rst_n),
            .ce         (ce),
            .prev_valid (sr_valid[g]),
            .prev_data  (sr_data[g]),
            .valid      (sr_valid[g+1]),
            .data       (sr_data[g+1])
        );
    end

    always_comb
    begin
        out_next.zero_length = sr_data[SRCH_STEPS].tag.zero_len;
        if (sr_data[SRCH_STEPS].tag.zero_len)
            out_next.angle_deg = '0;
        else if (sr_data[SRCH_STEPS].tag.dzero)
            out_next.angle_deg = ANGLE_RIGHT;
        else if (sr_data[SRCH_STEPS].tag.dneg)
            out_next.angle_deg = ANGLE_MAX - {1'b0, sr_data[SRCH_STEPS].lo};
        else
            out_next.angle_deg = {1'b0, sr_data[SRCH_STEPS].lo};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ce)
            out_valid_reg <= sr_valid[SRCH_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

// ===== src/vad_div_step.sv =====
// One restoring division step: one quotient bit per pipeline stage.
`default_nettype none
module vad_div_step
    import vad_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     ce,
    input  wire logic     prev_valid,
    input  wire vad_div_t prev_data,
    output logic          valid,
    output vad_div_t      data
);

    logic                 valid_reg;
    vad_div_t             data_reg;
    vad_div_t             data_next;
    logic [WIDE_BITS:0]   shifted;
    logic [WIDE_BITS:0]   diff;
    logic                 ge;

    always_comb
    begin
        shifted   = {prev_data.rem, 1'b0};
        diff      = shifted - {1'b0, prev_data.den};
        ge        = shifted >= {1'b0, prev_data.den};
        data_next = prev_data;
        data_next.rem = ge ? diff[WIDE_BITS-1:0] : shifted[WIDE_BITS-1:0];
        data_next.quo = {prev_data.quo[QUO_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ce)
            valid_reg <= prev_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule
`default_nettype wire

// ===== src/vad_search_step.sv =====
// One step of the binary search over the cosine threshold table.
`default_nettype none
module vad_search_step
    import vad_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      ce,
    input  wire logic      prev_valid,
    input  wire vad_srch_t prev_data,
    output logic           valid,
    output vad_srch_t      data
);

    logic                valid_reg;
    vad_srch_t           data_reg;
    vad_srch_t           data_next;
    logic [IDX_BITS:0]   span;
    logic [IDX_BITS-1:0] mid;
    logic [QUO_BITS-1:0] thr;
    logic                pred;

    always_comb
    begin
        span      = {1'b0, prev_data.lo} + {1'b0, prev_data.hi};
        mid       = span[IDX_BITS:1];
        thr       = {1'b0, COS_SQ[mid]};
        pred      = (thr > prev_data.quo) || ((thr == prev_data.quo) && prev_data.eq_ok);
        data_next = prev_data;
        if (prev_data.lo < prev_data.hi)
        begin
            if (pred)
                data_next.lo = mid + 1'b1;
            else
                data_next.hi = mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ce)
            valid_reg <= prev_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule
`default_nettype wire

// ===== sim/tb_vector_angle_degrees_3d.sv =====
// Testbench for the 3D vector angle block: directed and random vector pairs with a scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module tb_vector_angle_degrees_3d
    import vad_pkg::*;
;

    localparam int RANDOM_PAIRS = 1400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 120;

    class angle_scoreboard;
        logic [63:0] cos_half_q32 [90];
        vad_out_t    pending [$];
        int          mismatches;
        int          pairs_seen;
        int          results_seen;
        int          zero_seen;
        int          angle_hits [181];

        function new();
            logic [63:0]        x;
            logic [63:0]        x2;
            logic [63:0]        term;
            logic signed [63:0] sum;
            for (int j = 0; j < 90; j++)
            begin
                x    = (64'h3243F6A8885A308D / 64'd360) * 64'(2 * j + 1);
                x2   = mul_q60(x, x);
                term = 64'h1000000000000000;
                sum  = 64'sh1000000000000000;
                for (int n = 1; n <= 30; n++)
                begin
                    term = mul_q60(term, x2) / 64'((2 * n - 1) * (2 * n));
                    if (n % 2 == 1)
                        sum = sum - $signed(term);
                    else
                        sum = sum + $signed(term);
                end
                if (sum < 0)
                    sum = 0;
                cos_half_q32[j] = (64'(sum) + 64'h8000000) >> 28;
            end
            mismatches   = 0;
            pairs_seen   = 0;
            results_seen = 0;
            zero_seen    = 0;
            foreach (angle_hits[i])
                angle_hits[i] = 0;
        endfunction

        function logic [63:0] mul_q60(logic [63:0] p, logic [63:0] q);
            logic [127:0] prod;
            prod = {64'd0, p} * {64'd0, q};
            return prod[123:60];
        endfunction

        // True when the angle is at least k + 0.5 degrees; exact on squared integers.
        function bit past_half_degree(int k, logic [63:0] dmag, bit dneg, logic [127:0] norm_sq);
            bit           upper;
            logic [63:0]  tm;
            logic [191:0] lhs;
            logic [191:0] rhs;
            upper = (k < 90);
            tm    = cos_half_q32[upper ? k : 179 - k];
            if (upper && (dneg || dmag == 0))
                return 1;
            if (!upper && !(dneg && dmag != 0))
                return 0;
            lhs = {({64'd0, dmag} * {64'd0, dmag}), 64'd0};
            rhs = {128'd0, 64'(tm * tm)} * {64'd0, norm_sq};
            return upper ? (lhs <= rhs) : (lhs >= rhs);
        endfunction

        function vad_out_t angle_of(vad_in_t v);
            logic signed [63:0] a [3];
            logic signed [63:0] b [3];
            logic [63:0]        ma, mb, a2, b2, pos, neg, dmag;
            logic [127:0]       norm_sq;
            bit                 dneg;
            int                 lo, hi, mid;
            vad_out_t           r;
            a[0] = v.ax; a[1] = v.ay; a[2] = v.az;
            b[0] = v.bx; b[1] = v.by; b[2] = v.bz;
            a2 = 0; b2 = 0; pos = 0; neg = 0;
            for (int i = 0; i < 3; i++)
            begin
                ma = (a[i] < 0) ? 64'(-a[i]) : 64'(a[i]);
                mb = (b[i] < 0) ? 64'(-b[i]) : 64'(b[i]);
                a2 += ma * ma;
                b2 += mb * mb;
                if ((a[i] < 0) != (b[i] < 0))
                    neg += ma * mb;
                else
                    pos += ma * mb;
            end
            if (a2 == 0 || b2 == 0)
            begin
                r.angle_deg   = '0;
                r.zero_length = 1'b1;
                return r;
            end
            dneg    = neg > pos;
            dmag    = dneg ? neg - pos : pos - neg;
            norm_sq = {64'd0, a2} * {64'd0, b2};
            lo = 0;
            hi = 180;
            while (lo < hi)
            begin
                mid = (lo + hi) / 2;
                if (past_half_degree(mid, dmag, dneg, norm_sq))
                    lo = mid + 1;
                else
                    hi = mid;
            end
            r.angle_deg   = ANGLE_BITS'(lo);
            r.zero_length = 1'b0;
            return r;
        endfunction

        function void note_pair(vad_in_t v);
            vad_out_t r;
            r = angle_of(v);
            pending.push_back(r);
            pairs_seen++;
            if (r.zero_length)
                zero_seen++;
            else
                angle_hits[r.angle_deg]++;
        endfunction

        function void check_angle(vad_out_t got);
            vad_out_t want;
            results_seen++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result beat with nothing expected: angle %0d zero %0b",
                             got.angle_deg, got.zero_length);
                return;
            end
            want = pending.pop_front();
            if (got.angle_deg !== want.angle_deg || got.zero_length !== want.zero_length)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d: expected angle %0d zero %0b, got angle %0d zero %0b",
                             results_seen, want.angle_deg, want.zero_length,
                             got.angle_deg, got.zero_length);
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    vad_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    vad_out_t out_data;

    angle_scoreboard board;
    int              cycle_count;
    int              burst_left;

    vector_angle_degrees_3d u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        board     = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;
    end

    // Both sides of the handshake are sampled here, before any edge update lands.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.note_pair(in_data);
            if (out_valid && !out_stall)
                board.check_angle(out_data);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // The receiver switches among four stall styles in turn as the cycle count grows.
    always @(negedge clk)
    begin
        case ((cycle_count / 300) % 4)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 99) < 30);
            2: out_stall <= ($urandom_range(0, 99) < 75);
            default: out_stall <= ((cycle_count % 7) < 3);
        endcase
    end

    // Leaves valid high after the accepting edge; the caller lowers it when a run ends.
    task automatic send_pair(vad_in_t v);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
            burst_left = $urandom_range(1, 40);
            repeat (gap)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= v;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    function automatic vad_in_t make_pair(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                                          logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
        vad_in_t v;
        v.ax = ax; v.ay = ay; v.az = az;
        v.bx = bx; v.by = by; v.bz = bz;
        return v;
    endfunction

    function automatic logic [31:0] random_coord(int style);
        case (style)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 200)) - 100);
            2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return $urandom_range(0, 1) ? 32'h80000000 : 32'h7FFFFFFF;
        endcase
    endfunction

    function automatic vad_in_t random_pair();
        vad_in_t     v;
        int          kind;
        int          style;
        logic [31:0] d;
        kind  = $urandom_range(0, 99);
        style = $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3);
        v = make_pair(random_coord(style), random_coord(style), random_coord(style),
                      random_coord(style), random_coord(style), random_coord(style));
        if (kind < 20)
        begin
            // Near-parallel or near-antiparallel: small angles sit on rounding edges.
            d = $urandom_range(0, 1) ? 32'd0 : 32'($signed($urandom_range(0, 64)) - 32);
            if ($urandom_range(0, 1))
            begin
                v.bx = v.ax >>> 1; v.by = (v.ay >>> 1) + d; v.bz = v.az >>> 1;
            end
            else
            begin
                v.bx = -(v.ax >>> 1); v.by = -(v.ay >>> 1) + d; v.bz = -(v.az >>> 1);
            end
        end
        else if (kind < 30)
        begin
            // Perpendicular in a plane, with a nudge.
            v.az = 0; v.bz = random_coord(1);
            v.bx = -(v.ay >>> 2); v.by = (v.ax >>> 2) + 32'($urandom_range(0, 3));
        end
        else if (kind < 34)
        begin
            if ($urandom_range(0, 1))
            begin
                v.ax = 0; v.ay = 0; v.az = 0;
            end
            else
            begin
                v.bx = 0; v.by = 0; v.bz = 0;
            end
        end
        return v;
    endfunction

    initial
    begin
        vad_in_t directed [$];
        burst_left  = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed.push_back(make_pair(0, 0, 0, 0, 0, 0));
        directed.push_back(make_pair(0, 0, 0, 32'h10000, 0, 0));
        directed.push_back(make_pair(32'h10000, 0, 0, 0, 0, 0));
        directed.push_back(make_pair(32'h10000, 0, 0, 32'h10000, 0, 0));
        directed.push_back(make_pair(32'h10000, 0, 0, 32'hFFFF0000, 0, 0));
        directed.push_back(make_pair(32'h10000, 0, 0, 0, 32'h10000, 0));
        directed.push_back(make_pair(1, 1, 0, 0, 0, 1));
        directed.push_back(make_pair(1, 0, 0, 1, 1, 0));
        directed.push_back(make_pair(1, 0, 0, -1, 1, 0));
        directed.push_back(make_pair(1, 1, 1, -1, -1, -1));
        directed.push_back(make_pair(32'h80000000, 32'h80000000, 32'h80000000,
                                     32'h80000000, 32'h80000000, 32'h80000000));
        directed.push_back(make_pair(32'h80000000, 32'h80000000, 32'h80000000,
                                     32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        directed.push_back(make_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                     32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        directed.push_back(make_pair(32'h7FFFFFFF, 32'h80000000, 0, 32'h7FFFFFFF, 0, 0));
        directed.push_back(make_pair(32'h80000000, 0, 0, 0, 0, 32'h7FFFFFFF));
        directed.push_back(make_pair(1000, 1, 0, 1000, -1, 0));
        directed.push_back(make_pair(1000000, 8727, 0, 1000000, 0, 0));
        directed.push_back(make_pair(1000000, 0, 1, -1000000, 0, 0));
        directed.push_back(make_pair(1, 0, 0, 32'h80000000, 0, 1));
        directed.push_back(make_pair(0, 0, 1, 0, 0, 0));
        foreach (directed[i])
            send_pair(directed[i]);
        in_valid <= 1'b0;

        // Hold the sender off until the pipeline has fully drained.
        while (board.pending.size() != 0)
            @(negedge clk);

        for (int i = 0; i < RANDOM_PAIRS; i++)
            send_pair(random_pair());
        in_valid <= 1'b0;

        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Checked %0d result beats from %0d vector pairs; %0d had a zero vector.",
                 board.results_seen, board.pairs_seen, board.zero_seen);
        $display("Angles hit: 0 deg %0d, 90 deg %0d, 180 deg %0d times.",
                 board.angle_hits[0], board.angle_hits[90], board.angle_hits[180]);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
src/vad_pkg.sv
src/vad_div_step.sv
src/vad_search_step.sv
src/vector_angle_degrees_3d.sv
sim/tb_vector_angle_degrees_3d.sv
